FILE: rtl/assert_macros.svh
// assertion macros used by the top level rtl file
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// condition a implies b in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// condition a implies b in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, a, b)
`define ASSERT_NEXT(lbl, clk, rst, a, b)
`endif

`endif

FILE: rtl/hts_pkg.sv
// types and constants of the heightfield triangle sampler
// used by all modules of the block but hts_ram; no dependencies
package hts_pkg;

  localparam int MAX_NODES_X_DEF = 64;
  localparam int MAX_NODES_Z_DEF = 64;

  // configuration register indexes
  localparam logic [2:0] REG_CELL_SIZE = 3'd0;
  localparam logic [2:0] REG_ORIGIN_X  = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z  = 3'd2;
  localparam logic [2:0] REG_COUNT_X   = 3'd3;
  localparam logic [2:0] REG_COUNT_Z   = 3'd4;

  localparam int PAW = 5;

  // commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // divider sizes
  localparam int DVW = 58;
  localparam int DSW = 25;
  localparam int DCW = 6;

  typedef struct packed {
    logic [23:0]        cell_size;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_z;
    logic [6:0]         count_x;
    logic [6:0]         count_z;
  } cfg_t;

  // classified transaction between front and back
  typedef struct packed {
    logic               cmd;
    logic               bad;
    logic [5:0]         node_x;
    logic [5:0]         node_z;
    logic signed [31:0] height;
    logic [31:0]        ox;
    logic [31:0]        oz;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: rtl/hts_ram.sv
// generic single write port ram with registered read
// no dependencies
module hts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/hts_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on hts_pkg
module hts_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [hts_pkg::DVW-1:0] dividend,
  input  logic [hts_pkg::DCW-1:0] steps,
  input  logic [hts_pkg::DSW-1:0] divisor,
  output logic done,
  output logic [hts_pkg::DVW-1:0] quot,
  output logic [hts_pkg::DSW-1:0] rem
);
  import hts_pkg::*;

  logic [DVW-1:0] dvd;
  logic [DSW-1:0] dsr;
  logic [DCW-1:0] cnt;
  logic [DSW:0]   r_sh;
  logic           ge;

  // one shift-subtract step
  assign r_sh = {rem, dvd[DVW-1]};
  assign ge   = r_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= steps;
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == DCW'(1));
    end else begin
      done <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      dsr  <= divisor;
      rem  <= '0;
      quot <= '0;
    end else if (cnt != '0) begin
      dvd  <= {dvd[DVW-2:0], 1'b0};
      rem  <= ge ? DSW'(r_sh - {1'b0, dsr}) : r_sh[DSW-1:0];
      quot <= {quot[DVW-2:0], ge};
    end
  end

endmodule

FILE: rtl/hts_front.sv
// front part: accepts transactions and classifies them
// depends on hts_pkg
module hts_front #(
  parameter int MAX_NODES_X = hts_pkg::MAX_NODES_X_DEF,
  parameter int MAX_NODES_Z = hts_pkg::MAX_NODES_Z_DEF
) (
  input  hts_pkg::cfg_t cfg,
  input  logic          cmd,
  input  logic [5:0]    node_x,
  input  logic [5:0]    node_z,
  input  logic signed [31:0] height,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_z,
  output hts_pkg::job_t job
);
  import hts_pkg::*;

  localparam int CXW = ($clog2(MAX_NODES_X + 1) > 7) ? $clog2(MAX_NODES_X + 1) : 7;
  localparam int CZW = ($clog2(MAX_NODES_Z + 1) > 7) ? $clog2(MAX_NODES_Z + 1) : 7;

  logic [CXW-1:0]     ecx;
  logic [CZW-1:0]     ecz;
  logic signed [32:0] ox;
  logic signed [32:0] oz;
  logic               bad_w;
  logic               bad_q;

  // counts clamped to the grid size
  assign ecx = (CXW'(cfg.count_x) > CXW'(MAX_NODES_X)) ? CXW'(MAX_NODES_X)
                                                      : CXW'(cfg.count_x);
  assign ecz = (CZW'(cfg.count_z) > CZW'(MAX_NODES_Z)) ? CZW'(MAX_NODES_Z)
                                                      : CZW'(cfg.count_z);

  // offsets from the grid origin
  assign ox = 33'(pos_x) - 33'(cfg.origin_x);
  assign oz = 33'(pos_z) - 33'(cfg.origin_z);

  // early rejects
  assign bad_w = (CXW'(node_x) >= ecx) || (CZW'(node_z) >= ecz);
  assign bad_q = (cfg.cell_size == '0) || ox[32] || oz[32];

  always_comb begin
    job.cmd    = cmd;
    job.bad    = (cmd == CMD_WRITE) ? bad_w : bad_q;
    job.node_x = node_x;
    job.node_z = node_z;
    job.height = height;
    job.ox     = ox[31:0];
    job.oz     = oz[31:0];
  end

endmodule

FILE: rtl/hts_queue.sv
// two-entry queue between front and back
// depends on hts_pkg
module hts_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hts_pkg::job_t    din,
  input  logic             pop,
  output hts_pkg::job_t    head,
  output hts_pkg::q_stat_t stat
);
  import hts_pkg::*;

  job_t       ent [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;

  assign head       = ent[rptr];
  assign stat.full  = cnt == 2'd2;
  assign stat.empty = cnt == 2'd0;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= din;
    end
  end

endmodule

FILE: rtl/hts_back.sv
// back part: node writes, cell search, node reads and plane interpolation
// depends on hts_pkg, hts_ram, hts_div
module hts_back #(
  parameter int MAX_NODES_X = hts_pkg::MAX_NODES_X_DEF,
  parameter int MAX_NODES_Z = hts_pkg::MAX_NODES_Z_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  hts_pkg::cfg_t cfg,
  input  hts_pkg::job_t job,
  input  logic          job_valid,
  output logic          pop,
  output logic          clearing,
  output logic          out_valid,
  input  logic          out_stall,
  output logic signed [31:0] result_height,
  output logic          out_of_range
);
  import hts_pkg::*;

  localparam int DEPTH = MAX_NODES_X * MAX_NODES_Z;
  localparam int AW    = $clog2(DEPTH);
  localparam int CCW   = $clog2(DEPTH + 1);
  localparam int XW    = $clog2(MAX_NODES_X);
  localparam int ZW    = $clog2(MAX_NODES_Z);
  localparam int CXW = ($clog2(MAX_NODES_X + 1) > 7) ? $clog2(MAX_NODES_X + 1) : 7;
  localparam int CZW = ($clog2(MAX_NODES_Z + 1) > 7) ? $clog2(MAX_NODES_Z + 1) : 7;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIVX = 4'd1;
  localparam logic [3:0] S_DIVZ = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_RD0  = 4'd4;
  localparam logic [3:0] S_RD1  = 4'd5;
  localparam logic [3:0] S_RD2  = 4'd6;
  localparam logic [3:0] S_RD3  = 4'd7;
  localparam logic [3:0] S_SUM  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;
  localparam logic [3:0] S_DIVF = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]     state;
  logic [CCW-1:0] clr_cnt;
  logic [CXW-1:0] ecx;
  logic [CZW-1:0] ecz;
  logic           free;

  logic [31:0]    ix;
  logic [31:0]    iz;
  logic [31:0]    oz_q;
  logic [23:0]    fx;
  logic [23:0]    fz;
  logic [23:0]    w0;
  logic [23:0]    w1;
  logic [23:0]    w2;
  logic [AW-1:0]  a0;
  logic [AW-1:0]  a1;
  logic [AW-1:0]  a2;
  logic           neg;
  logic signed [31:0] res;

  logic [XW-1:0]  xn0;
  logic [XW-1:0]  xn1;
  logic [ZW-1:0]  zn0;
  logic [ZW-1:0]  zn1;
  logic           sel;
  logic           cell_bad;

  logic signed [31:0] mul_h;
  logic [23:0]        mul_w;
  logic signed [56:0] mul;
  logic signed [56:0] prod;
  logic signed [57:0] acc;
  logic signed [57:0] num2;

  logic           div_start;
  logic [DVW-1:0] div_dvd;
  logic [DCW-1:0] div_steps;
  logic [DSW-1:0] div_dsr;
  logic           div_done;
  logic [DVW-1:0] div_q;
  logic [DSW-1:0] div_r;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [31:0]    ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [31:0]    ram_rdata;
  logic [AW-1:0]  wr_addr;

  assign ecx = (CXW'(cfg.count_x) > CXW'(MAX_NODES_X)) ? CXW'(MAX_NODES_X)
                                                      : CXW'(cfg.count_x);
  assign ecz = (CZW'(cfg.count_z) > CZW'(MAX_NODES_Z)) ? CZW'(MAX_NODES_Z)
                                                      : CZW'(cfg.count_z);

  assign clearing = clr_cnt < CCW'(DEPTH);
  assign free     = !out_valid || !out_stall;
  assign pop      = (state == S_IDLE) && !clearing && job_valid && free;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // node store
  assign wr_addr   = AW'(AW'(job.node_z) * AW'(ecx) + AW'(job.node_x));
  assign ram_we    = clearing || (pop && job.cmd == CMD_WRITE && !job.bad);
  assign ram_waddr = clearing ? clr_cnt[AW-1:0] : wr_addr;
  assign ram_wdata = clearing ? 32'd0 : job.height;

  always_comb begin
    case (state)
      S_RD1:   ram_raddr = a1;
      S_RD2:   ram_raddr = a2;
      default: ram_raddr = a0;
    endcase
  end

  hts_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // shared divider: cell index x, cell index z, then final rounding
  assign num2 = (acc <<< 1) + 58'(cfg.cell_size);

  always_comb begin
    div_start = 1'b0;
    div_dvd   = {job.ox, 26'd0};
    div_steps = DCW'(32);
    div_dsr   = DSW'(cfg.cell_size);
    case (state)
      S_IDLE: begin
        div_start = pop && job.cmd == CMD_QUERY && !job.bad;
      end
      S_DIVX: begin
        div_start = div_done;
        div_dvd   = {oz_q, 26'd0};
      end
      S_FIN: begin
        div_start = 1'b1;
        div_dvd   = num2[57] ? ~num2 : num2;
        div_steps = DCW'(DVW);
        div_dsr   = {cfg.cell_size, 1'b0};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  hts_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd),
    .steps(div_steps), .divisor(div_dsr), .done(div_done),
    .quot(div_q), .rem(div_r)
  );

  // cell check, triangle choice and node addresses
  assign cell_bad = (33'(ix) + 33'd1 >= 33'(ecx)) || (33'(iz) + 33'd1 >= 33'(ecz));
  assign sel = fx >= fz;
  assign xn0 = ix[XW-1:0];
  assign xn1 = XW'(ix[XW-1:0] + 1'b1);
  assign zn0 = iz[ZW-1:0];
  assign zn1 = ZW'(iz[ZW-1:0] + 1'b1);

  // one multiplier, one product per cycle
  always_comb begin
    case (state)
      S_RD2:   mul_w = w1;
      S_RD3:   mul_w = w2;
      default: mul_w = w0;
    endcase
  end
  assign mul_h = $signed(ram_rdata);
  assign mul   = mul_h * $signed({1'b0, mul_w});

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (div_start) state <= S_DIVX;
        S_DIVX: if (div_done) state <= S_DIVZ;
        S_DIVZ: if (div_done) state <= S_CHK;
        S_CHK:  state <= cell_bad ? S_OUT : S_RD0;
        S_RD0:  state <= S_RD1;
        S_RD1:  state <= S_RD2;
        S_RD2:  state <= S_RD3;
        S_RD3:  state <= S_SUM;
        S_SUM:  state <= S_FIN;
        S_FIN:  state <= S_DIVF;
        S_DIVF: if (div_done) state <= S_OUT;
        S_OUT:  if (free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        // the queue head moves on at pop, keep the z offset
        if (pop) begin
          oz_q <= job.oz;
        end
      end
      S_DIVX: begin
        if (div_done) begin
          ix <= div_q[31:0];
          fx <= div_r[23:0];
        end
      end
      S_DIVZ: begin
        if (div_done) begin
          iz <= div_q[31:0];
          fz <= div_r[23:0];
        end
      end
      S_CHK: begin
        res <= '0;
        w0  <= cfg.cell_size - (sel ? fx : fz);
        w1  <= sel ? (fx - fz) : (fz - fx);
        w2  <= sel ? fz : fx;
        a0  <= AW'(AW'(zn0) * AW'(ecx) + AW'(xn0));
        a1  <= sel ? AW'(AW'(zn0) * AW'(ecx) + AW'(xn1))
                   : AW'(AW'(zn1) * AW'(ecx) + AW'(xn0));
        a2  <= AW'(AW'(zn1) * AW'(ecx) + AW'(xn1));
      end
      S_RD1: begin
        prod <= mul;
      end
      S_RD2: begin
        prod <= mul;
        acc  <= 58'(prod);
      end
      S_RD3: begin
        prod <= mul;
        acc  <= acc + 58'(prod);
      end
      S_SUM: begin
        acc <= acc + 58'(prod);
      end
      S_FIN: begin
        neg <= num2[57];
      end
      S_DIVF: begin
        if (div_done) begin
          res <= neg ? ~div_q[31:0] : div_q[31:0];
        end
      end
      default: begin
        neg <= neg;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((pop && (job.cmd == CMD_WRITE || job.bad)) ||
                 (state == S_OUT && free)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (job.cmd == CMD_WRITE || job.bad)) begin
      result_height <= '0;
      out_of_range  <= job.bad;
    end else if (state == S_OUT && free) begin
      result_height <= res;
      out_of_range  <= cell_bad;
    end
  end

endmodule

FILE: rtl/heightfield_triangle_sampler_top.sv
// top level of the heightfield triangle sampler: config registers,
// front, queue and back; depends on hts_pkg, hts_front, hts_queue, hts_back
//
// channel  direction  handshake            payload
// cfg      in         psel/penable/pready  paddr, pwdata, prdata
// in       in         in_valid/in_stall    cmd, node_x, node_z, height, pos_x, pos_z
// out      out        out_valid/out_stall  result_height, out_of_range
//
// a write or an early-rejected query sets the output register when it leaves the queue;
// any other query runs the radix-2 divider for cell indexes x and z, and if the cell
// is in the grid reads and weights the three nodes, then divides for final rounding
// after reset a clearing pass zeroes all MAX_NODES_X*MAX_NODES_Z nodes of the store
// the two-entry queue lets the front accept while the back works or out stalls
module heightfield_triangle_sampler_top #(
  parameter int MAX_NODES_X = hts_pkg::MAX_NODES_X_DEF,
  parameter int MAX_NODES_Z = hts_pkg::MAX_NODES_Z_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [hts_pkg::PAW-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    cmd,
  input  logic [5:0]              node_x,
  input  logic [5:0]              node_z,
  input  logic signed [31:0]      height,
  input  logic signed [31:0]      pos_x,
  input  logic signed [31:0]      pos_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [31:0]      result_height,
  output logic                    out_of_range
);
  import hts_pkg::*;
  `include "assert_macros.svh"

  cfg_t    cfg;
  job_t    fjob;
  job_t    head;
  q_stat_t qstat;
  logic    push;
  logic    pop;
  logic    clearing;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[PAW-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_size <= 24'd256;
      cfg.origin_x  <= '0;
      cfg.origin_z  <= '0;
      cfg.count_x   <= 7'd64;
      cfg.count_z   <= 7'd64;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_CELL_SIZE: cfg.cell_size <= pwdata[23:0];
        REG_ORIGIN_X:  cfg.origin_x  <= pwdata;
        REG_ORIGIN_Z:  cfg.origin_z  <= pwdata;
        REG_COUNT_X:   cfg.count_x   <= pwdata[6:0];
        REG_COUNT_Z:   cfg.count_z   <= pwdata[6:0];
        default:       cfg.count_z   <= cfg.count_z;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (ridx)
      REG_CELL_SIZE: prdata = {8'd0, cfg.cell_size};
      REG_ORIGIN_X:  prdata = cfg.origin_x;
      REG_ORIGIN_Z:  prdata = cfg.origin_z;
      REG_COUNT_X:   prdata = {25'd0, cfg.count_x};
      REG_COUNT_Z:   prdata = {25'd0, cfg.count_z};
      default:       prdata = 32'd0;
    endcase
  end

  // input transaction acceptance
  assign in_stall = clearing || qstat.full;
  assign push     = in_valid && !in_stall;

  hts_front #(.MAX_NODES_X(MAX_NODES_X), .MAX_NODES_Z(MAX_NODES_Z)) u_front (
    .cfg(cfg), .cmd(cmd), .node_x(node_x), .node_z(node_z), .height(height),
    .pos_x(pos_x), .pos_z(pos_z), .job(fjob)
  );

  hts_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .din(fjob), .pop(pop),
    .head(head), .stat(qstat)
  );

  hts_back #(.MAX_NODES_X(MAX_NODES_X), .MAX_NODES_Z(MAX_NODES_Z)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .job(head), .job_valid(!qstat.empty),
    .pop(pop), .clearing(clearing), .out_valid(out_valid), .out_stall(out_stall),
    .result_height(result_height), .out_of_range(out_of_range)
  );

  // checks
  `ASSERT_IMPLIES(a_flag_zero, clk, rst, out_valid && out_of_range, result_height == 32'd0)
  `ASSERT_IMPLIES(a_no_take_clear, clk, rst, clearing, !push && !pop)
  `ASSERT_IMPLIES(a_queue_level, clk, rst, qstat.full, !qstat.empty)
  `ASSERT_NEXT(a_pop_nonempty, clk, rst, qstat.empty && !push, !pop)

endmodule

FILE: dv/hts_checker.sv
// result checker for the heightfield triangle sampler
// depends on hts_pkg; watches the input and output channels and the config port
module hts_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [hts_pkg::PAW-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               cmd,
  input  logic [5:0]         node_x,
  input  logic [5:0]         node_z,
  input  logic signed [31:0] height,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] result_height,
  input  logic               out_of_range,
  output int                 fail_count,
  output int                 pending
);
  import hts_pkg::*;

  typedef struct packed {
    logic [31:0] hgt;
    logic        flag;
  } sample_t;

  logic [31:0] grid [0:4095];
  logic [23:0] cs_r;
  logic signed [31:0] ox_r, oz_r;
  logic [6:0] cx_r, cz_r;
  sample_t samples_due [$];

  assign pending = samples_due.size();

  function automatic longint node_h(longint x, longint z);
    longint off;
    longint ecx;
    ecx = (cx_r > 64) ? 64 : cx_r;
    off = z * ecx + x;
    if (off >= 4096) return 0;
    return longint'($signed(grid[off]));
  endfunction

  // compute the response for one transaction and update the grid
  function automatic sample_t sample_height(logic c, logic [5:0] nx, logic [5:0] nz,
                                            logic signed [31:0] h, logic signed [31:0] px,
                                            logic signed [31:0] pz);
    sample_t s;
    longint ecx, ecz, csz, dx, dz, ix, iz, fx, fz, num, n2, d2, q;
    ecx = (cx_r > 64) ? 64 : cx_r;
    ecz = (cz_r > 64) ? 64 : cz_r;
    s = '0;
    if (c == CMD_WRITE) begin
      if (nx >= ecx || nz >= ecz) s.flag = 1'b1;
      else if (nz * ecx + nx < 4096) grid[nz * ecx + nx] = h;
    end else begin
      csz = cs_r;
      dx = longint'(px) - longint'(ox_r);
      dz = longint'(pz) - longint'(oz_r);
      if (csz == 0 || dx < 0 || dz < 0) s.flag = 1'b1;
      else begin
        ix = dx / csz;
        iz = dz / csz;
        if (ix + 1 >= ecx || iz + 1 >= ecz) s.flag = 1'b1;
        else begin
          fx = dx - ix * csz;
          fz = dz - iz * csz;
          if (fx >= fz)
            num = node_h(ix, iz) * (csz - fx) + node_h(ix + 1, iz) * (fx - fz)
                + node_h(ix + 1, iz + 1) * fz;
          else
            num = node_h(ix, iz) * (csz - fz) + node_h(ix, iz + 1) * (fz - fx)
                + node_h(ix + 1, iz + 1) * fx;
          n2 = 2 * num + csz;
          d2 = 2 * csz;
          q = n2 / d2;
          if ((n2 % d2) != 0 && n2 < 0) q--;
          s.hgt = q[31:0];
        end
      end
    end
    return s;
  endfunction

  always @(posedge clk) begin
    sample_t s;
    if (rst) begin
      for (int i = 0; i < 4096; i++) grid[i] = '0;
      cs_r <= 24'd256; ox_r <= 0; oz_r <= 0; cx_r <= 7'd64; cz_r <= 7'd64;
      samples_due.delete();
      fail_count <= 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_CELL_SIZE: cs_r <= pwdata[23:0];
          REG_ORIGIN_X:  ox_r <= pwdata;
          REG_ORIGIN_Z:  oz_r <= pwdata;
          REG_COUNT_X:   cx_r <= pwdata[6:0];
          REG_COUNT_Z:   cz_r <= pwdata[6:0];
          default: ;
        endcase
      end
      // input transaction
      if (in_valid && !in_stall)
        samples_due.push_back(sample_height(cmd, node_x, node_z, height, pos_x, pos_z));
      // output transaction
      if (out_valid && !out_stall) begin
        if (samples_due.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h %b", result_height, out_of_range);
          fail_count <= fail_count + 1;
        end else begin
          s = samples_due.pop_front();
          if (s.hgt !== result_height || s.flag !== out_of_range) begin
            if (fail_count < 10)
              $display("mismatch: expected %h/%b got %h/%b",
                       s.hgt, s.flag, result_height, out_of_range);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: dv/tb.sv
// testbench top for the heightfield triangle sampler: stimulus and verdict
// depends on hts_pkg, heightfield_triangle_sampler_top and hts_checker
module tb;
  import hts_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PAW-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid = 1'b0, in_stall;
  logic cmd = 1'b0;
  logic [5:0] node_x = '0, node_z = '0;
  logic signed [31:0] height = 0, pos_x = 0, pos_z = 0;
  logic out_valid, out_stall = 1'b0;
  logic signed [31:0] result_height;
  logic out_of_range;
  int fail_count, pending;
  int idle_cycles;
  logic out_taken = 1'b0;
  int rx_wait = 0;
  logic [23:0] cur_cs;
  logic [6:0] cur_cx, cur_cz;
  logic signed [31:0] cur_ox, cur_oz;

  localparam int WATCHDOG_LIMIT = 20000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  heightfield_triangle_sampler_top dut (.*);
  hts_checker u_checker (.*);

  // receiver stall pattern: a fresh random wait after each result
  always @(posedge clk) begin
    out_taken <= out_valid && !out_stall;
  end

  always @(negedge clk) begin
    if (out_taken) rx_wait = $urandom_range(0, 11);
    if (rx_wait != 0) begin
      out_stall <= 1'b1;
      rx_wait = rx_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on accepted transactions
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic set_grid(logic [23:0] cs, logic signed [31:0] ox, logic signed [31:0] oz,
                          logic [6:0] cx, logic [6:0] cz);
    drain();
    reg_write(REG_CELL_SIZE, {8'd0, cs});
    reg_write(REG_ORIGIN_X, ox);
    reg_write(REG_ORIGIN_Z, oz);
    reg_write(REG_COUNT_X, {25'd0, cx});
    reg_write(REG_COUNT_Z, {25'd0, cz});
    cur_cs = cs; cur_ox = ox; cur_oz = oz; cur_cx = cx; cur_cz = cz;
  endtask

  // send one transaction after a random gap, hold until accepted
  task automatic send(logic c, logic [5:0] nx, logic [5:0] nz, logic signed [31:0] h,
                      logic signed [31:0] px, logic signed [31:0] pz, bit gap = 1);
    int n;
    n = gap ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    cmd <= c; node_x <= nx; node_z <= nz; height <= h; pos_x <= px; pos_z <= pz;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // query somewhere near the configured grid, or now and then at a random position
  task automatic rand_query();
    longint span_x, span_z, px, pz;
    span_x = longint'(cur_cs) * cur_cx;
    span_z = longint'(cur_cs) * cur_cz;
    px = longint'(cur_ox) + $urandom_range(0, 31) - 16
       + (longint'($urandom) % (span_x + 64));
    pz = longint'(cur_oz) + $urandom_range(0, 31) - 16
       + (longint'($urandom) % (span_z + 64));
    if ($urandom_range(0, 15) == 0) send(CMD_QUERY, 0, 0, 0, $urandom, $urandom);
    else send(CMD_QUERY, 6'($urandom), 6'($urandom), $urandom, px[31:0], pz[31:0]);
  endtask

  task automatic rand_write();
    logic [5:0] nx, nz;
    nx = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, cur_cx - 1));
    nz = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, cur_cz - 1));
    send(CMD_WRITE, nx, nz, $urandom, $urandom, $urandom);
  endtask

  initial begin
    cur_cs = 24'd256; cur_ox = 0; cur_oz = 0; cur_cx = 7'd64; cur_cz = 7'd64;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes at reset settings
    send(CMD_QUERY, 0, 0, 0, 32'sd128, 32'sd128);
    send(CMD_WRITE, 0, 0, 32'h7fffffff, 0, 0);
    send(CMD_WRITE, 1, 0, 32'h80000000, 0, 0);
    send(CMD_WRITE, 0, 1, 32'sd1000, 0, 0);
    send(CMD_WRITE, 1, 1, -32'sd1, 0, 0);
    send(CMD_WRITE, 63, 63, 32'sd5, 0, 0);
    send(CMD_QUERY, 0, 0, 0, 32'sd200, 32'sd50);
    send(CMD_QUERY, 0, 0, 0, 32'sd50, 32'sd200);
    send(CMD_QUERY, 0, 0, 0, 32'sd100, 32'sd100);
    send(CMD_QUERY, 0, 0, 0, 0, 0);
    send(CMD_QUERY, 63, 63, 32'hffffffff, -32'sd1, 32'sd10);
    send(CMD_QUERY, 0, 0, 0, 32'sd10, -32'sd1);
    send(CMD_QUERY, 0, 0, 0, 32'sd63 * 256, 32'sd10);
    send(CMD_QUERY, 0, 0, 0, 32'h7fffffff, 32'h80000000);
    send(CMD_QUERY, 0, 0, 0, 32'sd62 * 256 + 255, 32'sd62 * 256 + 255);

    // zero cell size and zero counts
    set_grid(24'd0, 0, 0, 7'd4, 7'd4);
    send(CMD_QUERY, 0, 0, 0, 32'sd10, 32'sd10);
    set_grid(24'd256, 0, 0, 7'd0, 7'd0);
    send(CMD_WRITE, 0, 0, 32'sd7, 0, 0);
    send(CMD_QUERY, 0, 0, 0, 32'sd10, 32'sd10);
    // counts above the maximum, extreme cell size and origins
    set_grid(24'hffffff, 32'h80000000, 32'h80000000, 7'd127, 7'd127);
    send(CMD_WRITE, 63, 63, 32'sd9, 0, 0);
    send(CMD_QUERY, 0, 0, 0, 32'h7fffffff, 32'h7fffffff);
    send(CMD_QUERY, 0, 0, 0, 32'h80000000, 32'h80000000);
    set_grid(24'd1, 32'h7fffffff, 32'h7fffffff, 7'd2, 7'd2);
    send(CMD_QUERY, 0, 0, 0, 32'h7fffffff, 32'h7fffffff);

    // random phases over several grid settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: set_grid(24'($urandom_range(1, 1024)), $signed($urandom_range(0, 4095)) - 2048,
                    $signed($urandom_range(0, 4095)) - 2048,
                    7'($urandom_range(2, 8)), 7'($urandom_range(2, 8)));
        1: set_grid(24'($urandom_range(1, 16)), -32'sd100, 32'sd100,
                    7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)));
        2: set_grid(24'($urandom), $urandom, $urandom, 7'($urandom_range(2, 5)),
                    7'($urandom_range(2, 5)));
        default: set_grid(24'd256, 0, 0, 7'd64, 7'd64);
      endcase
      for (int i = 0; i < 120; i++) begin
        if ($urandom_range(0, 2) == 0) rand_write();
        else rand_query();
        // a full drain halfway through each phase
        if (i == 60) drain();
      end
    end

    drain();
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

FILE: files.f
+incdir+rtl
rtl/hts_pkg.sv
rtl/hts_ram.sv
rtl/hts_div.sv
rtl/hts_front.sv
rtl/hts_queue.sv
rtl/hts_back.sv
rtl/heightfield_triangle_sampler_top.sv
dv/hts_checker.sv
dv/tb.sv
